### src/ssq_pkg.sv
// Shared constants, types and helpers for the sorted sleep timer queue.
package ssq_pkg;

   localparam int QUEUE_DEPTH = 64;
   localparam int MAX_RESULTS = 64;

   localparam int ADDR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
   localparam int POP_W  = $clog2(MAX_RESULTS + 1);

   localparam int ID_W    = 6;
   localparam int SECS_W  = 16;
   localparam int TIME_W  = 48;
   localparam int UPS_W   = 24;
   localparam int PROD_W  = SECS_W + UPS_W;
   localparam int ENTRY_W = ID_W + TIME_W;

   localparam logic [UPS_W-1:0]  UPS_RESET = UPS_W'(1000000);
   localparam logic [TIME_W-1:0] TIME_MAX  = {TIME_W{1'b1}};

   // Input command codes
   localparam logic CMD_SLEEP = 1'b0;
   localparam logic CMD_TICK  = 1'b1;

   // Controller to datapath
   typedef struct packed {
      logic calc_mul;   // register seconds times units per second
      logic calc_add;   // form saturated wake time, load scan position
      logic clear_pop;  // restart release count for a tick
      logic rd_scan;    // read slot before scan position instead of head
      logic shift;      // move read entry up one slot, step position down
      logic place;      // write new entry at scan position
      logic pop;        // release head entry into pending holder
      logic flush;      // emit pending id as the final beat
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic is_tick;
      logic full;
      logic count_zero;
      logic pos_zero;
      logic later;      // read entry wakes after the new entry
      logic expired;    // read entry wakes before current time
      logic popped_max;
      logic pend_valid;
      logic out_free;
   } status_type;

   // Add two slot offsets modulo the queue depth
   function automatic logic [ADDR_W-1:0] ssq_wrap(input logic [ADDR_W:0] sum);
      logic [ADDR_W:0] adj;
      adj = sum;
      if (sum >= (ADDR_W+1)'(QUEUE_DEPTH)) begin
         adj = sum - (ADDR_W+1)'(QUEUE_DEPTH);
      end
      return adj[ADDR_W-1:0];
   endfunction

endpackage

### src/sorted_sleep_timer_queue.sv
// Top level of the sorted sleep timer queue: controller plus datapath.
//
//   channel  direction  handshake          payload
//   req      in         req_valid/ready    command, requester_id, sleep_seconds, current_time
//   rsp      out        rsp_valid/ready    woken_id, last_woken
//   csr      in         csr_wr_en          units_per_second (24 bits)
//
// A sleep keeps req_ready low through multiply and add (only these on a full list), then
// a scan and a compare per later entry moved up a slot, and a last scan plus, unless it
// lands at the head, a last compare. A tick keeps it low through multiply, check and flush,
// with a check and a compare per released entry, one more compare when an unexpired head
// stops the release; the single read port sets these pairs. Reset clears occupancy and
// loads units_per_second with 1000000; the store needs no clearing pass. Output stalls hold
// the release loop, one id pending, and req_ready stays low until the current item finishes.
module sorted_sleep_timer_queue
   import ssq_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_command,
   input  logic [ID_W-1:0]   req_requester_id,
   input  logic [SECS_W-1:0] req_sleep_seconds,
   input  logic [TIME_W-1:0] req_current_time,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [ID_W-1:0]   rsp_woken_id,
   output logic              rsp_last_woken,
   input  logic              csr_wr_en,
   input  logic [UPS_W-1:0]  csr_wr_data
);

   cmd_type    cmd;
   status_type status;
   logic       req_accept;

   assign req_accept = req_valid && req_ready;

   ssq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   ssq_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .req_accept        (req_accept),
      .req_command       (req_command),
      .req_requester_id  (req_requester_id),
      .req_sleep_seconds (req_sleep_seconds),
      .req_current_time  (req_current_time),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_woken_id      (rsp_woken_id),
      .rsp_last_woken    (rsp_last_woken),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .cmd               (cmd),
      .status            (status)
   );

endmodule

### src/ssq_ram.sv
// Generic single write port, single registered read port RAM.
module ssq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write on enable, register the read every cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### src/ssq_ctrl.sv
// Controller state machine sequencing inserts and tick releases.
module ssq_ctrl
   import ssq_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_MUL,
      S_ADD,
      S_SCAN,
      S_CMP,
      S_TCHK,
      S_TCMP,
      S_FLUSH
   } state_type;

   state_type state_ff, state_in;

   // Decode next state and datapath commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            cmd.calc_mul  = 1'b1;
            cmd.clear_pop = 1'b1;
            state_in      = status.is_tick ? S_TCHK : S_ADD;
         end
         S_ADD: begin
            cmd.calc_add = 1'b1;
            state_in     = status.full ? S_IDLE : S_SCAN;
         end
         S_SCAN: begin
            cmd.rd_scan = 1'b1;
            if (status.pos_zero) begin
               cmd.place = 1'b1;
               state_in  = S_IDLE;
            end else begin
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            cmd.rd_scan = 1'b1;
            if (status.later) begin
               cmd.shift = 1'b1;
               state_in  = S_SCAN;
            end else begin
               cmd.place = 1'b1;
               state_in  = S_IDLE;
            end
         end
         S_TCHK: begin
            state_in = (status.count_zero || status.popped_max) ? S_FLUSH : S_TCMP;
         end
         S_TCMP: begin
            if (!status.expired) begin
               state_in = S_FLUSH;
            end else if (!status.pend_valid || status.out_free) begin
               cmd.pop  = 1'b1;
               state_in = S_TCHK;
            end
         end
         S_FLUSH: begin
            if (!status.pend_valid) begin
               state_in = S_IDLE;
            end else if (status.out_free) begin
               cmd.flush = 1'b1;
               state_in  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### src/ssq_datapath.sv
// Datapath: wake time arithmetic, circular sorted store, release and output beat.
module ssq_datapath
   import ssq_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_accept,
   input  logic              req_command,
   input  logic [ID_W-1:0]   req_requester_id,
   input  logic [SECS_W-1:0] req_sleep_seconds,
   input  logic [TIME_W-1:0] req_current_time,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [ID_W-1:0]   rsp_woken_id,
   output logic              rsp_last_woken,
   input  logic              csr_wr_en,
   input  logic [UPS_W-1:0]  csr_wr_data,
   input  cmd_type           cmd,
   output status_type        status
);

   logic              is_tick_ff;
   logic [ID_W-1:0]   id_ff;
   logic [SECS_W-1:0] secs_ff;
   logic [TIME_W-1:0] now_ff;
   logic [PROD_W-1:0] product_ff;
   logic [TIME_W-1:0] wake_ff, wake_in;
   logic [UPS_W-1:0]  ups_ff;
   logic [ADDR_W-1:0] head_ff;
   logic [CNT_W-1:0]  count_ff;
   logic [ADDR_W-1:0] pos_ff;
   logic [POP_W-1:0]  popped_ff;
   logic [ID_W-1:0]   pend_id_ff;
   logic              pend_valid_ff;
   logic              rsp_valid_ff;
   logic [ID_W-1:0]   rsp_id_ff;
   logic              rsp_last_ff;

   logic [TIME_W:0]    sum;
   logic [ADDR_W-1:0]  pos_dec;
   logic [ADDR_W-1:0]  rd_addr;
   logic [ADDR_W-1:0]  wr_addr;
   logic [ENTRY_W-1:0] wr_data;
   logic [ENTRY_W-1:0] rd_data;
   logic               wr_en;
   logic [ID_W-1:0]    rd_id;
   logic [TIME_W-1:0]  rd_wake;
   logic               out_free;
   logic               emit;

   // Saturate wake time at the top of the time range
   assign sum     = {1'b0, now_ff} + {{(TIME_W + 1 - PROD_W){1'b0}}, product_ff};
   assign wake_in = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];

   // Address the circular store relative to head
   assign pos_dec = pos_ff - ADDR_W'(1);
   assign rd_addr = cmd.rd_scan ? ssq_wrap({1'b0, head_ff} + {1'b0, pos_dec}) : head_ff;
   assign wr_addr = ssq_wrap({1'b0, head_ff} + {1'b0, pos_ff});
   assign wr_en   = cmd.shift | cmd.place;
   assign wr_data = cmd.shift ? rd_data : {id_ff, wake_ff};
   assign rd_id   = rd_data[ENTRY_W-1:TIME_W];
   assign rd_wake = rd_data[TIME_W-1:0];

   ssq_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign emit     = (cmd.pop && pend_valid_ff) || cmd.flush;

   // Report status
   always_comb begin
      status.is_tick    = is_tick_ff;
      status.full       = (count_ff == CNT_W'(QUEUE_DEPTH));
      status.count_zero = (count_ff == '0);
      status.pos_zero   = (pos_ff == '0);
      status.later      = (rd_wake > wake_ff);
      status.expired    = (rd_wake < now_ff);
      status.popped_max = (popped_ff == POP_W'(MAX_RESULTS));
      status.pend_valid = pend_valid_ff;
      status.out_free   = out_free;
   end

   // Capture request beat and compute wake time
   always_ff @(posedge clock) begin
      if (req_accept) begin
         is_tick_ff <= (req_command == CMD_TICK);
         id_ff      <= req_requester_id;
         secs_ff    <= req_sleep_seconds;
         now_ff     <= req_current_time;
      end
      if (cmd.calc_mul) begin
         product_ff <= PROD_W'(secs_ff) * PROD_W'(ups_ff);
      end
      if (cmd.calc_add) begin
         wake_ff <= wake_in;
      end
      if (cmd.pop) begin
         pend_id_ff <= rd_id;
      end
      if (emit) begin
         rsp_id_ff   <= pend_id_ff;
         rsp_last_ff <= cmd.flush;
      end
   end

   // Scan position: load at insert start, step down on each shift
   always_ff @(posedge clock) begin
      if (cmd.calc_add) begin
         pos_ff <= count_ff[ADDR_W-1:0];
      end else if (cmd.shift) begin
         pos_ff <= pos_dec;
      end
   end

   // Queue control state, release count, pending id and output beat
   always_ff @(posedge clock) begin
      if (reset) begin
         ups_ff        <= UPS_RESET;
         head_ff       <= '0;
         count_ff      <= '0;
         popped_ff     <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            ups_ff <= csr_wr_data;
         end
         if (cmd.place) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (cmd.pop) begin
            count_ff <= count_ff - CNT_W'(1);
         end
         if (cmd.pop) begin
            head_ff <= ssq_wrap({1'b0, head_ff} + (ADDR_W+1)'(1));
         end
         if (cmd.clear_pop) begin
            popped_ff <= '0;
         end else if (cmd.pop) begin
            popped_ff <= popped_ff + POP_W'(1);
         end
         if (cmd.pop) begin
            pend_valid_ff <= 1'b1;
         end else if (cmd.flush) begin
            pend_valid_ff <= 1'b0;
         end
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_woken_id   = rsp_id_ff;
   assign rsp_last_woken = rsp_last_ff;

   // Occupancy never passes the depth
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("queue occupancy above depth");

   // Release count stays within the per-tick limit
   assert property (@(posedge clock) disable iff (reset)
      popped_ff <= POP_W'(MAX_RESULTS))
      else $error("release count above limit");

   // Insert grows the queue by exactly one
   assert property (@(posedge clock) disable iff (reset)
      cmd.place |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("insert did not grow occupancy by one");

   // Releasing behind a pending id emits a non-final beat
   assert property (@(posedge clock) disable iff (reset)
      cmd.pop && pend_valid_ff |=> rsp_valid_ff && !rsp_last_ff)
      else $error("pending id not emitted as non-final beat");

   // Never emit into an occupied output register
   assert property (@(posedge clock) disable iff (reset)
      emit |-> out_free)
      else $error("output beat overwritten");

endmodule

### test/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for the sorted sleep timer queue: stimulus, wake-up model, checker.
module tb_top;
   import ssq_pkg::*;

   localparam int SETTLE_CYCLES  = 2 * QUEUE_DEPTH + 16;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int REPORT_LIMIT   = 10;

   typedef struct packed {
      logic              command;
      logic [ID_W-1:0]   requester_id;
      logic [SECS_W-1:0] sleep_seconds;
      logic [TIME_W-1:0] current_time;
   } req_beat_type;

   typedef struct packed {
      logic [ID_W-1:0] woken_id;
      logic            last_woken;
   } wake_beat_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic              req_command = CMD_SLEEP;
   logic [ID_W-1:0]   req_requester_id = '0;
   logic [SECS_W-1:0] req_sleep_seconds = '0;
   logic [TIME_W-1:0] req_current_time = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [ID_W-1:0]   rsp_woken_id;
   logic              rsp_last_woken;
   logic              csr_wr_en = 1'b0;
   logic [UPS_W-1:0]  csr_wr_data = '0;

   // Stimulus side
   req_beat_type      req_backlog[$];
   logic              req_fire = 1'b0;
   int                send_idle_pct = 0;
   int                stall_pct = 0;
   logic [UPS_W-1:0]  gen_rate = UPS_RESET;
   logic [TIME_W-1:0] sim_now = '0;
   logic [TIME_W-1:0] horizon = '0;
   int                rates_written = 0;

   // Model of the sleeper list and the wake-ups it owes
   logic [ID_W-1:0]   held_ids[QUEUE_DEPTH];
   logic [TIME_W-1:0] held_wakes[QUEUE_DEPTH];
   int                held = 0;
   logic [UPS_W-1:0]  rate_model = UPS_RESET;
   wake_beat_type     due_wakeups[$];

   // Run statistics
   int fault_count = 0;
   int sleeps_taken = 0;
   int ticks_taken = 0;
   int beats_checked = 0;
   int full_drops = 0;
   int peak_release = 0;
   int quiet_cycles = 0;

   sorted_sleep_timer_queue dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_command       (req_command),
      .req_requester_id  (req_requester_id),
      .req_sleep_seconds (req_sleep_seconds),
      .req_current_time  (req_current_time),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_woken_id      (rsp_woken_id),
      .rsp_last_woken    (rsp_last_woken),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Saturated wake time for a sleep of secs seconds starting at now
   function automatic logic [TIME_W-1:0] wake_for(input logic [TIME_W-1:0] now,
                                                  input logic [SECS_W-1:0] secs,
                                                  input logic [UPS_W-1:0]  rate);
      logic [63:0] sum;
      sum = 64'(now) + 64'(secs) * 64'(rate);
      return (sum > 64'(TIME_MAX)) ? TIME_MAX : sum[TIME_W-1:0];
   endfunction

   // Insert a sleeper behind every entry waking at the same time or earlier
   function automatic void admit_sleeper(input logic [ID_W-1:0]   id,
                                         input logic [SECS_W-1:0] secs,
                                         input logic [TIME_W-1:0] now);
      logic [TIME_W-1:0] wake;
      int pos;
      int k;
      wake = wake_for(now, secs, rate_model);
      if (held >= QUEUE_DEPTH) begin
         full_drops++;
         return;
      end
      pos = 0;
      while (pos < held && held_wakes[pos] <= wake) pos++;
      for (k = held; k > pos; k--) begin
         held_ids[k]   = held_ids[k-1];
         held_wakes[k] = held_wakes[k-1];
      end
      held_ids[pos]   = id;
      held_wakes[pos] = wake;
      held++;
   endfunction

   // Pop head entries that woke strictly before now, up to the per-tick limit, and owe their ids
   function automatic void release_expired(input logic [TIME_W-1:0] now);
      wake_beat_type beat;
      int n;
      int k;
      n = 0;
      while (n < held && n < MAX_RESULTS && held_wakes[n] < now) n++;
      for (k = 0; k < n; k++) begin
         beat.woken_id   = held_ids[k];
         beat.last_woken = (k == n - 1);
         due_wakeups.push_back(beat);
      end
      for (k = 0; k < held - n; k++) begin
         held_ids[k]   = held_ids[k+n];
         held_wakes[k] = held_wakes[k+n];
      end
      held -= n;
      if (n > peak_release) peak_release = n;
   endfunction

   function automatic void plan_sleep(input logic [ID_W-1:0]   id,
                                      input logic [SECS_W-1:0] secs,
                                      input logic [TIME_W-1:0] now);
      req_beat_type beat;
      logic [TIME_W-1:0] wake;
      beat.command       = CMD_SLEEP;
      beat.requester_id  = id;
      beat.sleep_seconds = secs;
      beat.current_time  = now;
      req_backlog.push_back(beat);
      wake = wake_for(now, secs, gen_rate);
      if (wake > horizon) horizon = wake;
   endfunction

   function automatic void plan_tick(input logic [TIME_W-1:0] now);
      req_beat_type beat;
      beat.command       = CMD_TICK;
      beat.requester_id  = ID_W'($urandom);
      beat.sleep_seconds = SECS_W'($urandom);
      beat.current_time  = now;
      req_backlog.push_back(beat);
   endfunction

   // Mostly short sleeps, with the extremes and full-range values mixed in
   function automatic logic [SECS_W-1:0] draw_seconds();
      int roll;
      roll = $urandom_range(99);
      if (roll < 75) return SECS_W'($urandom_range(0, 5));
      if (roll < 80) return '1;
      if (roll < 85) return '0;
      return SECS_W'($urandom);
   endfunction

   task automatic run_random_phase(input int quota);
      logic [TIME_W-1:0] span;
      logic [TIME_W-1:0] odd_time;
      int made;
      int roll;
      int burst;
      int k;
      span  = (gen_rate == '0) ? TIME_W'(4) : TIME_W'(gen_rate);
      made  = 0;
      burst = 70;
      while (made < quota) begin
         roll = $urandom_range(99);
         if (burst == 0 && roll < 2) burst = $urandom_range(20, 70);
         if (burst != 0) begin
            // Pile sleepers on one moment, at times overflowing the list, then tick past all of them
            for (k = 0; k < burst; k++) plan_sleep(ID_W'($urandom), draw_seconds(), sim_now);
            sim_now = (horizon >= sim_now) ? horizon + 1'b1 : sim_now;
            plan_tick(sim_now);
            made += burst + 1;
            burst = 0;
         end else if (roll < 7) begin
            // Noise: either command at an arbitrary time below the top bit
            odd_time = {1'b0, 15'($urandom), 32'($urandom)};
            if ($urandom_range(1) == 0) begin
               plan_sleep(ID_W'($urandom), SECS_W'($urandom), odd_time);
            end else begin
               plan_tick(odd_time);
            end
            made++;
         end else if (roll < 50) begin
            plan_sleep(ID_W'($urandom), draw_seconds(), sim_now);
            made++;
         end else begin
            sim_now = sim_now + TIME_W'($urandom_range(0, 3)) * span
                    + TIME_W'($urandom_range(0, 32'(span)));
            plan_tick(sim_now);
            made++;
         end
      end
   endtask

   // Wait until every request is taken and every wake-up is back, then let inserts finish
   task automatic drain_and_settle();
      do @(negedge clock);
      while (req_backlog.size() != 0 || req_valid || due_wakeups.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_rate(input logic [UPS_W-1:0] value);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      gen_rate = value;
      rates_written++;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Drive request beats from the backlog; hold each beat until it is taken
   always @(negedge clock) begin
      req_beat_type beat;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (req_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            beat = req_backlog.pop_front();
            req_command       <= beat.command;
            req_requester_id  <= beat.requester_id;
            req_sleep_seconds <= beat.sleep_seconds;
            req_current_time  <= beat.current_time;
            req_valid         <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Stall the wake-up channel at random
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // Check wake-up beats, advance the model on taken requests, watch for hangs
   always @(posedge clock) begin
      wake_beat_type due;
      if (reset) begin
         req_fire <= 1'b0;
         quiet_cycles = 0;
      end else begin
         req_fire <= req_valid && req_ready;
         if (csr_wr_en) rate_model = csr_wr_data;
         if (rsp_valid && rsp_ready) begin
            beats_checked++;
            if (due_wakeups.size() == 0) begin
               fault_count++;
               if (fault_count <= REPORT_LIMIT) begin
                  $display("unexpected wake-up beat: id %0d last %0b",
                           rsp_woken_id, rsp_last_woken);
               end
            end else begin
               due = due_wakeups.pop_front();
               if (rsp_woken_id !== due.woken_id || rsp_last_woken !== due.last_woken) begin
                  fault_count++;
                  if (fault_count <= REPORT_LIMIT) begin
                     $display("wake-up mismatch: expected id %0d last %0b, got id %0d last %0b",
                              due.woken_id, due.last_woken, rsp_woken_id, rsp_last_woken);
                  end
               end
            end
         end
         if (req_valid && req_ready) begin
            if (req_command == CMD_SLEEP) begin
               sleeps_taken++;
               admit_sleeper(req_requester_id, req_sleep_seconds, req_current_time);
            end else begin
               ticks_taken++;
               release_expired(req_current_time);
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("no beat on either channel for %0d cycles", quiet_cycles);
            $display("tb_top NOT OK");
            $finish;
         end
      end
   end

   initial begin
      int k;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part at the reset rate of one million units per second
      plan_tick(TIME_W'(0));                      // empty list: nothing to release
      plan_sleep(6'd0, 16'd0, TIME_W'(0));        // zero seconds: wakes at 0
      plan_sleep(6'd63, '1, TIME_W'(0));          // longest sleep
      plan_sleep(6'd5, 16'd1, TIME_W'(1000));
      plan_sleep(6'd5, 16'd1, TIME_W'(1000));     // same id queued twice
      plan_sleep(6'd7, 16'd1, TIME_W'(1000));     // equal wake keeps arrival order
      plan_tick(TIME_W'(0));                      // wake equal to now is not expired
      plan_tick(TIME_W'(1));                      // single release
      plan_tick(TIME_W'(1001000));                // equal again: nothing
      plan_tick(TIME_W'(1001001));                // three in arrival order
      plan_sleep(6'd42, 16'd2, TIME_W'(2000000));
      plan_sleep(6'd21, 16'd3, TIME_W'(0));       // goes to the front
      plan_sleep(6'd9, 16'h8000, TIME_W'(0));     // lands in the middle
      plan_tick(TIME_W'(64'd65535000001));
      sim_now = TIME_W'(64'd65535000001);
      drain_and_settle();

      // Random phases, one rate setting and one idling pattern each
      write_rate(UPS_W'(1));
      send_idle_pct = 0;
      stall_pct     = 0;
      run_random_phase(100);
      drain_and_settle();

      write_rate('1);
      send_idle_pct = 81;
      stall_pct     = 0;
      run_random_phase(100);
      drain_and_settle();

      write_rate('0);
      send_idle_pct = 0;
      stall_pct     = 81;
      run_random_phase(100);
      drain_and_settle();

      write_rate(UPS_W'($urandom_range(2, 1000000)));
      send_idle_pct = 28;
      stall_pct     = 28;
      run_random_phase(100);
      drain_and_settle();

      // Close at the top of the time range: clear the list, then saturate
      write_rate('1);
      send_idle_pct = 28;
      stall_pct     = 28;
      plan_tick(TIME_MAX);
      for (k = 0; k < 4; k++) begin
         plan_sleep(ID_W'($urandom), '0, TIME_MAX - TIME_W'($urandom_range(1, 1000)));
      end
      plan_tick(TIME_MAX);
      plan_sleep(ID_W'($urandom), '1, TIME_MAX);
      plan_sleep(ID_W'($urandom), 16'd1, TIME_MAX - TIME_W'(5));
      plan_sleep(ID_W'($urandom), '0, TIME_MAX);
      plan_tick(TIME_MAX);                        // saturated sleepers never expire
      drain_and_settle();

      if (due_wakeups.size() != 0) begin
         fault_count += due_wakeups.size();
         $display("%0d expected wake-up beats never arrived", due_wakeups.size());
      end
      $display("covered %0d sleeps and %0d ticks, %0d wake-up beats checked, %0d rate settings",
               sleeps_taken, ticks_taken, beats_checked, rates_written + 1);
      $display("sleeps dropped on a full list: %0d, largest single release: %0d",
               full_drops, peak_release);
      if (fault_count == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

endmodule
